// File: hw/rtl/kwm_pkg.sv
`timescale 1ns / 1ps

package kwm_pkg;

   localparam int KEY_W             = 32;
   localparam int LIST_W            = 4;
   localparam int COUNT_W           = 5;
   localparam int ENTRY_W           = KEY_W + LIST_W;
   localparam int REQ_DATA_W        = 40;
   localparam int RSP_DATA_W        = 40;
   localparam int LIST_LIMIT        = 16;
   localparam int MAX_LISTS_DEFAULT = 16;

   localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(LIST_LIMIT);
   localparam logic [KEY_W-1:0]   KEY_BIAS    = {1'b1, {(KEY_W-1){1'b0}}};

   typedef logic [ENTRY_W-1:0] entry_type;

   // The key is biased so that a plain unsigned compare of the whole entry orders signed keys
   // first and breaks ties on the lower stream number.
   function automatic entry_type make_entry(input logic [KEY_W-1:0] key,
                                            input logic [LIST_W-1:0] list);
      return {key ^ KEY_BIAS, list};
   endfunction

   function automatic logic [KEY_W-1:0] entry_key(input entry_type e);
      return e[ENTRY_W-1:LIST_W] ^ KEY_BIAS;
   endfunction

   function automatic logic [LIST_W-1:0] entry_list(input entry_type e);
      return e[LIST_W-1:0];
   endfunction

endpackage

// File: hw/rtl/kwm_heap_ram.sv
`timescale 1ns / 1ps

module kwm_heap_ram #(
   parameter int DEPTH = kwm_pkg::MAX_LISTS_DEFAULT,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  kwm_pkg::entry_type  wr_data,
   input  logic [AW-1:0]       rd_addr_a,
   input  logic [AW-1:0]       rd_addr_b,
   output kwm_pkg::entry_type  rd_data_a,
   output kwm_pkg::entry_type  rd_data_b
);
   import kwm_pkg::*;

   entry_type mem_ff [DEPTH];
   entry_type rd_a_ff;
   entry_type rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// File: hw/rtl/k_way_sorted_merge.sv
// Merges up to list_count ascending streams of signed 32-bit values into one ascending stream,
// keeping the head of every stream in a binary min-heap held in a small RAM.
// The req channel first takes one head item per stream (has_value low marks an empty stream),
// in any order. After the last head the smallest entry is popped and offered on the rsp channel
// with its source stream; the next req item must then come from that stream, and items from any
// other stream are taken and discarded. When the heap is empty a done item is sent instead.
// Equal keys leave in order of ascending stream number.
// csr_wr_en writes list_count; it should only be written while the block is idle.
// One item is worked on at a time through a single shared comparator and a RAM with registered
// reads. An insert reads the parent and compares once per heap level climbed; an extraction
// loads the top and last entries, then reads both children, selects the smaller and compares it
// with the last entry once per level descended, so a shallow heap finishes an item sooner.
// The rsp side has an output register, so a new req item is accepted while a result still waits;
// if the receiver stalls, the block finishes that item and then holds until the register is free.
// Reset is synchronous: it empties the heap, restarts the loading phase, clears any pending
// result and sets list_count to sixteen. The RAM itself needs no clearing.
`timescale 1ns / 1ps

module k_way_sorted_merge #(
   parameter int MAX_LISTS = kwm_pkg::MAX_LISTS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // list_index [3:0], key_value [35:4], zero [39:36]
   input  logic [kwm_pkg::REQ_DATA_W-1:0]    req_tdata,
   // has_value [0]
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // merged_value [31:0], source_list [35:32], zero [39:36]
   output logic [kwm_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // merge_done [0]
   output logic                              rsp_tuser,
   input  logic                              csr_wr_en,
   input  logic [kwm_pkg::COUNT_W-1:0]       csr_wr_data
);
   import kwm_pkg::*;

   localparam int AW    = $clog2(MAX_LISTS);
   localparam int SW    = $clog2(MAX_LISTS + 1);
   localparam int CW    = AW + 2;
   localparam int LIMIT = (MAX_LISTS < LIST_LIMIT) ? MAX_LISTS : LIST_LIMIT;
   localparam logic [COUNT_W-1:0] COUNT_LIMIT = COUNT_W'(LIMIT);
   localparam logic [SW-1:0]      HEAP_MAX    = SW'(MAX_LISTS);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PUSH_RD,
      ST_PUSH_CMP,
      ST_POP_START,
      ST_POP_LOAD,
      ST_POP_RD,
      ST_POP_SEL,
      ST_POP_CMP,
      ST_OUT
   } state_type;

   state_type            state_ff;
   logic [COUNT_W-1:0]   list_count_ff;
   logic [SW-1:0]        heap_size_ff;
   logic [COUNT_W-1:0]   heads_seen_ff;
   logic [LIST_W-1:0]    awaited_ff;
   entry_type            entry_ff;
   logic                 emit_ff;
   logic [AW-1:0]        hole_ff;
   entry_type            top_ff;
   entry_type            last_ff;
   entry_type            child_ff;
   logic [AW-1:0]        child_idx_ff;
   logic                 empty_ff;
   logic                 rsp_valid_ff;
   logic [KEY_W-1:0]     rsp_value_ff;
   logic [LIST_W-1:0]    rsp_list_ff;
   logic                 rsp_done_ff;

   logic [COUNT_W-1:0]   eff_count;
   logic [LIST_W-1:0]    in_list;
   logic [KEY_W-1:0]     in_key;
   logic                 loading;
   logic                 accept;
   logic                 heap_full;
   logic                 acc_take;
   logic                 acc_emit;
   logic                 acc_push;
   logic [AW-1:0]        parent;
   logic [CW-1:0]        left_c;
   logic [CW-1:0]        right_c;
   logic [CW-1:0]        size_c;
   logic                 sel_right;
   logic                 out_free;
   entry_type            cmp_a;
   entry_type            cmp_b;
   logic                 cmp_lt;

   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   entry_type            wr_data;
   logic [AW-1:0]        rd_addr_a;
   logic [AW-1:0]        rd_addr_b;
   entry_type            rd_data_a;
   entry_type            rd_data_b;

   kwm_heap_ram #(
      .DEPTH (MAX_LISTS),
      .AW    (AW)
   ) u_heap_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   always_comb begin
      if (list_count_ff == '0) begin
         eff_count = COUNT_W'(1);
      end else if (list_count_ff > COUNT_LIMIT) begin
         eff_count = COUNT_LIMIT;
      end else begin
         eff_count = list_count_ff;
      end
   end

   assign in_list    = req_tdata[LIST_W-1:0];
   assign in_key     = req_tdata[LIST_W+KEY_W-1:LIST_W];
   assign loading    = heads_seen_ff < eff_count;
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign heap_full  = heap_size_ff >= HEAP_MAX;
   assign acc_take   = loading || (in_list == awaited_ff);
   assign acc_emit   = loading ? ((heads_seen_ff + COUNT_W'(1)) >= eff_count) : 1'b1;
   assign acc_push   = acc_take && req_tuser && !heap_full;
   assign parent     = (hole_ff - AW'(1)) >> 1;
   assign left_c     = {1'b0, hole_ff, 1'b1};
   assign right_c    = left_c + CW'(1);
   assign size_c     = CW'(heap_size_ff);
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // The one comparator of the block, shared by sift-up and sift-down.
   always_comb begin
      case (state_ff)
         ST_PUSH_CMP: begin
            cmp_a = entry_ff;
            cmp_b = rd_data_a;
         end
         ST_POP_SEL: begin
            cmp_a = rd_data_b;
            cmp_b = rd_data_a;
         end
         ST_POP_CMP: begin
            cmp_a = child_ff;
            cmp_b = last_ff;
         end
         default: begin
            cmp_a = entry_ff;
            cmp_b = entry_ff;
         end
      endcase
   end

   assign cmp_lt    = cmp_a < cmp_b;
   assign sel_right = (right_c < size_c) && cmp_lt;

   always_comb begin
      wr_en     = 1'b0;
      wr_addr   = hole_ff;
      wr_data   = entry_ff;
      rd_addr_a = parent;
      rd_addr_b = AW'(heap_size_ff - SW'(1));
      case (state_ff)
         ST_PUSH_RD: begin
            wr_en = (hole_ff == '0);
         end
         ST_PUSH_CMP: begin
            wr_en   = 1'b1;
            wr_data = cmp_lt ? rd_data_a : entry_ff;
         end
         ST_POP_START: begin
            rd_addr_a = '0;
         end
         ST_POP_RD: begin
            rd_addr_a = left_c[AW-1:0];
            rd_addr_b = right_c[AW-1:0];
            wr_en     = (left_c >= size_c) && (heap_size_ff != '0);
            wr_data   = last_ff;
         end
         ST_POP_CMP: begin
            wr_en   = 1'b1;
            wr_data = cmp_lt ? child_ff : last_ff;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         list_count_ff <= COUNT_RESET;
         heap_size_ff  <= '0;
         heads_seen_ff <= '0;
         awaited_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            list_count_ff <= csr_wr_data;
         end
         if (rsp_valid_ff && rsp_tready && (state_ff != ST_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  entry_ff <= make_entry(in_key, in_list);
                  emit_ff  <= acc_emit;
                  if (loading) begin
                     heads_seen_ff <= heads_seen_ff + COUNT_W'(1);
                  end
                  if (acc_push) begin
                     hole_ff      <= AW'(heap_size_ff);
                     heap_size_ff <= heap_size_ff + SW'(1);
                     state_ff     <= ST_PUSH_RD;
                  end else if (acc_take && acc_emit) begin
                     state_ff <= ST_POP_START;
                  end
               end
            end
            ST_PUSH_RD: begin
               if (hole_ff == '0) begin
                  state_ff <= emit_ff ? ST_POP_START : ST_IDLE;
               end else begin
                  state_ff <= ST_PUSH_CMP;
               end
            end
            ST_PUSH_CMP: begin
               if (cmp_lt) begin
                  hole_ff  <= parent;
                  state_ff <= ST_PUSH_RD;
               end else begin
                  state_ff <= emit_ff ? ST_POP_START : ST_IDLE;
               end
            end
            ST_POP_START: begin
               if (heap_size_ff == '0) begin
                  empty_ff <= 1'b1;
                  state_ff <= ST_OUT;
               end else begin
                  empty_ff     <= 1'b0;
                  heap_size_ff <= heap_size_ff - SW'(1);
                  state_ff     <= ST_POP_LOAD;
               end
            end
            ST_POP_LOAD: begin
               top_ff   <= rd_data_a;
               last_ff  <= rd_data_b;
               hole_ff  <= '0;
               state_ff <= ST_POP_RD;
            end
            ST_POP_RD: begin
               state_ff <= (left_c >= size_c) ? ST_OUT : ST_POP_SEL;
            end
            ST_POP_SEL: begin
               child_ff     <= sel_right ? rd_data_b : rd_data_a;
               child_idx_ff <= sel_right ? right_c[AW-1:0] : left_c[AW-1:0];
               state_ff     <= ST_POP_CMP;
            end
            ST_POP_CMP: begin
               if (cmp_lt) begin
                  hole_ff  <= child_idx_ff;
                  state_ff <= ST_POP_RD;
               end else begin
                  state_ff <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  if (empty_ff) begin
                     rsp_value_ff <= '0;
                     rsp_list_ff  <= '0;
                     rsp_done_ff  <= 1'b1;
                  end else begin
                     rsp_value_ff <= entry_key(top_ff);
                     rsp_list_ff  <= entry_list(top_ff);
                     rsp_done_ff  <= 1'b0;
                     awaited_ff   <= entry_list(top_ff);
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-LIST_W-KEY_W){1'b0}}, rsp_list_ff, rsp_value_ff};
   assign rsp_tuser  = rsp_done_ff;

`ifndef SYNTHESIS
   a_heap_bound: assert property (@(posedge clock) disable iff (reset)
      heap_size_ff <= HEAP_MAX)
      else $error("Heap holds more entries than it has room for.");

   a_write_in_heap: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (SW'(wr_addr) < heap_size_ff))
      else $error("Heap RAM written outside the occupied entries.");

   a_heads_bound: assert property (@(posedge clock) disable iff (reset)
      heads_seen_ff <= COUNT_W'(LIST_LIMIT))
      else $error("More heads counted than streams can take part.");

   a_done_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == '0))
      else $error("A done item carries a value or a stream.");
`endif

endmodule

// File: bench/tb_k_way_sorted_merge.sv
`timescale 1ns / 1ps

module tb_k_way_sorted_merge;
   import kwm_pkg::*;

   localparam int STREAMS       = MAX_LISTS_DEFAULT;
   localparam int HEAP_CAP      = (STREAMS < LIST_LIMIT) ? STREAMS : LIST_LIMIT;
   localparam int ITEM_TARGET   = 1550;
   localparam int FINAL_STRETCH = 150;
   localparam int SETTLE_CYCLES = 40;
   localparam int HOLD_CYCLES   = 300;
   localparam int HOLD_AT       = 500;
   localparam int RATE_CHUNK    = 100;
   localparam int CSR_CHUNK     = 300;

   typedef struct packed {
      logic [KEY_W-1:0]  value;
      logic [LIST_W-1:0] stream;
      logic              done;
   } merge_out_type;

   class merge_tracker;
      entry_type          slots[LIST_LIMIT];
      int unsigned        heap_len;
      int unsigned        heads_loaded;
      int unsigned        items_taken;
      int unsigned        mismatches;
      logic [LIST_W-1:0]  wanted_stream;
      logic [COUNT_W-1:0] count_reg;
      merge_out_type      pending_merges[$];

      function new();
         heap_len      = 0;
         heads_loaded  = 0;
         items_taken   = 0;
         mismatches    = 0;
         wanted_stream = '0;
         count_reg     = COUNT_RESET;
      endfunction

      function int unsigned active_streams();
         int unsigned n;
         n = 32'(count_reg);
         if (n == 0) n = 1;
         if (n > HEAP_CAP) n = HEAP_CAP;
         return n;
      endfunction

      function bit loading();
         return heads_loaded < active_streams();
      endfunction

      function void push_entry(input entry_type e);
         int unsigned i;
         int unsigned p;
         if (heap_len >= HEAP_CAP) return;
         i = heap_len;
         heap_len++;
         while (i > 0) begin
            p = (i - 1) / 2;
            if (slots[p] <= e) break;
            slots[i] = slots[p];
            i = p;
         end
         slots[i] = e;
      endfunction

      function entry_type pop_min();
         entry_type   top;
         entry_type   tail;
         int unsigned i;
         int unsigned l;
         int unsigned m;
         top = slots[0];
         heap_len--;
         tail = slots[heap_len];
         i = 0;
         while (1'b1) begin
            l = 2 * i + 1;
            if (l >= heap_len) break;
            m = l;
            if (l + 1 < heap_len && slots[l + 1] < slots[l]) m = l + 1;
            if (tail <= slots[m]) break;
            slots[i] = slots[m];
            i = m;
         end
         if (heap_len > 0) slots[i] = tail;
         return top;
      endfunction

      function void queue_next();
         merge_out_type r;
         entry_type     e;
         if (heap_len == 0) begin
            r.value  = '0;
            r.stream = '0;
            r.done   = 1'b1;
         end else begin
            e = pop_min();
            wanted_stream = e[LIST_W-1:0];
            r.value  = e[ENTRY_W-1:LIST_W] ^ KEY_BIAS;
            r.stream = e[LIST_W-1:0];
            r.done   = 1'b0;
         end
         pending_merges.push_back(r);
      endfunction

      // Returns 1 when the item took part in the merge, 0 when the block drops it.
      function bit take_input(input logic [LIST_W-1:0] idx, input logic [KEY_W-1:0] key,
                              input logic has);
         entry_type e;
         e = {key ^ KEY_BIAS, idx};
         if (loading()) begin
            if (has) push_entry(e);
            heads_loaded++;
            if (!loading()) queue_next();
            items_taken++;
            return 1'b1;
         end
         if (idx != wanted_stream) return 1'b0;
         if (has) push_entry(e);
         queue_next();
         items_taken++;
         return 1'b1;
      endfunction

      function void check_output(input logic [RSP_DATA_W-1:0] data, input logic user);
         merge_out_type got;
         merge_out_type want;
         got.value  = data[KEY_W-1:0];
         got.stream = data[KEY_W+LIST_W-1:KEY_W];
         got.done   = user;
         if (pending_merges.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected item: value %h stream %0d done %b",
                        got.value, got.stream, got.done);
            return;
         end
         want = pending_merges.pop_front();
         if (got.value !== want.value || got.stream !== want.stream || got.done !== want.done)
         begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected %h stream %0d done %b, got %h stream %0d done %b",
                        want.value, want.stream, want.done, got.value, got.stream, got.done);
         end
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata;
   logic                   req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   rsp_tuser;
   logic                   csr_wr_en;
   logic [COUNT_W-1:0]     csr_wr_data;

   merge_tracker sb;
   int           gap_pct;
   int           stall_pct;
   bit           hold_request;
   int           stream_tail[STREAMS];

   k_way_sorted_merge #(.MAX_LISTS(STREAMS)) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("k_way_sorted_merge regression: fail");
      $finish;
   end

   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_tvalid && rsp_tready) sb.check_output(rsp_tdata, rsp_tuser);
   end

   initial begin : receiver
      rsp_tready = 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
      end
   end

   task automatic send_item(input logic [LIST_W-1:0] idx, input logic [KEY_W-1:0] key,
                            input logic has);
      req_tdata  <= {4'b0000, key, idx};
      req_tuser  <= has;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      void'(sb.take_input(idx, key, has));
      if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
   endtask

   // The block may still be busy with an item that gives no result, hence the settling time.
   task automatic write_count(input logic [COUNT_W-1:0] value);
      while (sb.pending_merges.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_data <= value;
      csr_wr_en   <= 1'b1;
      @(posedge clock);
      sb.count_reg = value;
      csr_wr_en   <= 1'b0;
   endtask

   initial begin : stimulus
      int unsigned        fresh[$];
      int unsigned        j;
      int unsigned        swap;
      int unsigned        left;
      int unsigned        next_rate;
      int unsigned        next_csr;
      int unsigned        plan_pos;
      bit                 hold_done;
      longint             sum;
      int unsigned        step;
      logic [LIST_W-1:0]  idx;
      logic [KEY_W-1:0]   key;
      logic               has;
      int                 rates[3];
      logic [COUNT_W-1:0] csr_plan[4];

      rates    = '{0, 15, 40};
      csr_plan = '{5'd16, 5'd1, 5'd17, 5'd0};
      sb = new();
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = 1'b0;
      csr_wr_en    = 1'b0;
      csr_wr_data  = '0;
      gap_pct      = 0;
      stall_pct    = 0;
      hold_request = 1'b0;
      for (int s = 0; s < STREAMS; s++) stream_tail[s] = int'($urandom());
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // A count of zero merges a single stream, here stream five.
      write_count(5'd0);
      send_item(4'd5, 32'h8000_0000, 1'b1);
      send_item(4'd3, 32'h0000_0001, 1'b1);
      send_item(4'd5, 32'h7FFF_FFFF, 1'b1);
      send_item(4'd5, 32'hFFFF_FFFF, 1'b0);
      send_item(4'd5, 32'h0000_0000, 1'b0);
      send_item(4'd5, 32'h0000_0000, 1'b1);
      req_tvalid <= 1'b0;

      // Two more heads with equal keys: the lower stream must leave first.
      write_count(5'd3);
      send_item(4'd1, 32'd7, 1'b1);
      send_item(4'd0, 32'd7, 1'b1);
      send_item(4'd0, 32'd0, 1'b0);
      send_item(4'd1, 32'd7, 1'b1);
      send_item(4'd1, 32'd0, 1'b0);
      req_tvalid <= 1'b0;

      // An out-of-range count acts as sixteen; the remaining heads arrive shuffled.
      write_count(5'd31);
      for (int s = 0; s < STREAMS; s++) if (s != 0 && s != 1 && s != 5) fresh.push_back(s);
      for (int i = fresh.size() - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         swap = fresh[i];
         fresh[i] = fresh[j];
         fresh[j] = swap;
      end
      for (int i = 0; i < fresh.size(); i++)
         send_item(LIST_W'(fresh[i]), stream_tail[fresh[i]], i != 0);

      next_rate = 0;
      next_csr  = sb.items_taken + CSR_CHUNK;
      plan_pos  = 0;
      hold_done = 1'b0;
      while (sb.items_taken < ITEM_TARGET) begin
         left = ITEM_TARGET - sb.items_taken;
         if (sb.items_taken >= next_csr && left > FINAL_STRETCH) begin
            req_tvalid <= 1'b0;
            write_count(csr_plan[plan_pos]);
            plan_pos = (plan_pos + 1) % 4;
            next_csr += CSR_CHUNK;
         end
         if (sb.items_taken >= next_rate) begin
            gap_pct   = rates[$urandom_range(0, 2)];
            stall_pct = rates[$urandom_range(0, 2)];
            next_rate += RATE_CHUNK;
         end
         if (left <= FINAL_STRETCH) begin
            gap_pct   = 0;
            stall_pct = 0;
         end
         if (!hold_done && sb.items_taken >= HOLD_AT) begin
            hold_request = 1'b1;
            hold_done    = 1'b1;
         end

         if (sb.loading()) begin
            idx = LIST_W'($urandom_range(0, 15));
            key = $urandom();
            has = 1'($urandom_range(0, 1));
         end else if ($urandom_range(0, 99) < 8) begin
            idx = sb.wanted_stream ^ 4'($urandom_range(1, 15));
            key = $urandom();
            has = 1'($urandom_range(0, 1));
         end else begin
            idx = sb.wanted_stream;
            if (left <= FINAL_STRETCH) has = $urandom_range(0, 2) != 0;
            else has = $urandom_range(0, 149) != 0;
            if ($urandom_range(0, 29) == 0) begin
               key = $urandom();
            end else begin
               if ($urandom_range(0, 9) == 0) step = 0;
               else if ($urandom_range(0, 8) == 0) step = $urandom_range(0, 1 << 28);
               else step = $urandom_range(0, 1000);
               sum = longint'(stream_tail[idx]) + longint'(step);
               if (sum > 64'sd2147483647) sum = 64'sd2147483647;
               stream_tail[idx] = int'(sum);
               key = stream_tail[idx];
            end
         end
         send_item(idx, key, has);
      end
      req_tvalid <= 1'b0;

      while (sb.pending_merges.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.mismatches == 0)
         $display("k_way_sorted_merge regression: pass");
      else
         $display("k_way_sorted_merge regression: fail");
      $finish;
   end

endmodule
